[hw/rtl/tilt_pkg.sv]
// tilt_pkg: shared constants and the arctangent table for the tilt angle unit
// no dependencies; used by tilt_smul, tilt_cordic and tilt_angle_from_imu_unit
package tilt_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN        = 24;

	// serial multiplier geometry
	localparam int FACT_W = 18;
	localparam int PROD_W = 64;

	// datapath widths
	localparam int XY_W = 40;
	localparam int CW_W = 44;
	localparam int Z_W  = 24;

	// configuration register indexes
	localparam logic [7:0] REG_RADIUS = 8'd0;
	localparam logic [7:0] REG_RATE   = 8'd1;

	localparam logic [15:0] RADIUS_RST = 16'd9830;
	localparam logic [12:0] RATE_RST   = 13'd100;

	// fixed-point coefficients
	localparam logic [FACT_W-1:0] CENT_COEF = 18'd133412;
	localparam logic [FACT_W-1:0] TAN_COEF  = 18'd59718;
	localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;

	// arctangent of 2^-i in 2^-20 rad
	function automatic logic [19:0] atan_q20(input logic [4:0] idx);
		logic [19:0] v;
		unique case (idx)
			5'd0:  v = 20'd823550;
			5'd1:  v = 20'd486170;
			5'd2:  v = 20'd256879;
			5'd3:  v = 20'd130396;
			5'd4:  v = 20'd65451;
			5'd5:  v = 20'd32757;
			5'd6:  v = 20'd16383;
			5'd7:  v = 20'd8192;
			5'd8:  v = 20'd4096;
			5'd9:  v = 20'd2048;
			5'd10: v = 20'd1024;
			5'd11: v = 20'd512;
			5'd12: v = 20'd256;
			5'd13: v = 20'd128;
			5'd14: v = 20'd64;
			5'd15: v = 20'd32;
			5'd16: v = 20'd16;
			5'd17: v = 20'd8;
			5'd18: v = 20'd4;
			5'd19: v = 20'd2;
			5'd20: v = 20'd1;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/tilt_angle_from_imu_unit.sv]
// tilt_angle_from_imu_unit: tilt angle from one imu sample with centripetal and tangential fix
// sequence: bit-serial multiplies, rounding and sums, normalizing (at most 40 doublings),
//   CORDIC_STEPS cordic steps and finish; zero skips cordic
// one sample at a time; the bit-serial multipliers, the cordic loop and output stalls set the rate
// the next sample is taken while the result beat still waits at the output register
// reset: radius 9830, sample rate 100, previous rate 0, no result pending
module tilt_angle_from_imu_unit #(
	parameter int CORDIC_STEPS = tilt_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] rate_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] angle,
	output logic               valid_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_CHK, S_COR, S_FIN} state_t;

	state_t                              state_q;
	logic [15:0]                         radius_q;
	logic [12:0]                         rate_q;
	logic signed [15:0]                  prev_q;
	logic signed [15:0]                  ax_q;
	logic signed [15:0]                  ay_q;
	logic                                dneg_q;
	logic [23:0]                         cw_q;
	logic [37:0]                         tw_q;
	logic signed [tilt_pkg::XY_W-1:0]    x_q;
	logic signed [tilt_pkg::XY_W-1:0]    y_q;
	logic signed [15:0]                  res_ang_q;
	logic                                res_vld_q;
	logic                                out_valid_q;
	logic signed [15:0]                  angle_q;
	logic                                valid_res_q;
	logic                                cor_start_q;

	logic                                in_acc;
	logic signed [16:0]                  d;
	logic [15:0]                         mr;
	logic [15:0]                         md;
	logic                                c_done;
	logic                                t_done;
	logic [tilt_pkg::PROD_W-1:0]         c_prod;
	logic [tilt_pkg::PROD_W-1:0]         t_prod;
	logic [tilt_pkg::PROD_W-1:0]         c_sum;
	logic [tilt_pkg::PROD_W-1:0]         t_sum;
	logic signed [tilt_pkg::XY_W-1:0]    tw_s;
	logic [tilt_pkg::XY_W-1:0]           x_abs;
	logic                                cor_done;
	logic [15:0]                         cor_ang;
	logic                                out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// rate magnitude and rate change
	assign d  = 17'(rate_z) - 17'(prev_q);
	assign mr = rate_z[15] ? 16'(-17'(rate_z)) : 16'(rate_z);
	assign md = d[16] ? 16'(-d) : 16'(d);

	// centripetal term: rate^2 * radius * coef
	tilt_smul u_cent (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.f0     (mr),
		.f1     (tilt_pkg::FACT_W'(mr)),
		.f2     (tilt_pkg::FACT_W'(radius_q)),
		.f3     (tilt_pkg::CENT_COEF),
		.done   (c_done),
		.prod   (c_prod)
	);

	// tangential term: |rate change| * sample rate * radius * coef
	tilt_smul u_tang (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.f0     (md),
		.f1     (tilt_pkg::FACT_W'(rate_q)),
		.f2     (tilt_pkg::FACT_W'(radius_q)),
		.f3     (tilt_pkg::TAN_COEF),
		.done   (t_done),
		.prod   (t_prod)
	);

	assign c_sum = c_prod + (tilt_pkg::PROD_W'(1) << 39);
	assign t_sum = t_prod + (tilt_pkg::PROD_W'(1) << 25);
	assign tw_s  = dneg_q ? -tilt_pkg::XY_W'(tw_q) : tilt_pkg::XY_W'(tw_q);
	assign x_abs = x_q[tilt_pkg::XY_W-1] ? tilt_pkg::XY_W'(-x_q) : tilt_pkg::XY_W'(x_q);

	tilt_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cor_start_q),
		.x_abs     (x_abs),
		.y_in      (y_q),
		.done      (cor_done),
		.mag_angle (cor_ang)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= tilt_pkg::RADIUS_RST;
			rate_q   <= tilt_pkg::RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tilt_pkg::REG_RADIUS) begin
				radius_q <= cfg_data;
			end else if (cfg_index == tilt_pkg::REG_RATE) begin
				rate_q <= cfg_data[12:0];
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			cor_start_q <= 1'b0;
		end else begin
			cor_start_q <= (state_q == S_CHK) && !(x_q == '0 && y_q == '0);
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						prev_q  <= rate_z;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (c_done && t_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_CHK;
				S_CHK: begin
					if (x_q == '0 && y_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_COR;
					end
				end
				S_COR: begin
					if (cor_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q   <= accel_x;
			ay_q   <= accel_y;
			dneg_q <= d[16];
		end
		if (state_q == S_MUL && c_done && t_done) begin
			cw_q <= c_sum[63:40];
			tw_q <= t_sum[63:26];
		end
		if (state_q == S_SUM) begin
			x_q <= (tilt_pkg::XY_W'(ax_q) <<< 8) + tw_s;
			y_q <= (tilt_pkg::XY_W'(ay_q) <<< 8) + tilt_pkg::XY_W'(cw_q);
		end
		if (state_q == S_CHK) begin
			res_ang_q <= '0;
			res_vld_q <= !(x_q == '0 && y_q == '0);
		end
		if (state_q == S_COR && cor_done) begin
			res_ang_q <= (x_q > 0) ? -$signed(cor_ang) : $signed(cor_ang);
		end
		if (state_q == S_FIN && out_free) begin
			angle_q     <= res_ang_q;
			valid_res_q <= res_vld_q;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign valid_res = valid_res_q;

	// a zero vector always reports angle zero
	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (angle == 16'sd0))
		else $error("invalid result with nonzero angle");

	// the angle stays within plus and minus pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle <= tilt_pkg::ANGLE_MAX && angle >= -tilt_pkg::ANGLE_MAX))
		else $error("angle out of range");

	// the cordic is only started with a nonzero vector
	a_cor_start: assert property (@(posedge clk) disable iff (!arst_n)
		cor_start_q |-> (state_q == S_COR && !(x_q == '0 && y_q == '0)))
		else $error("cordic started on zero vector");

endmodule

[hw/rtl/tilt_smul.sv]
// tilt_smul: bit-serial product of four factors, f0*f1*f2*f3, one multiplier bit a cycle
// depends on tilt_pkg
module tilt_smul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [15:0]                       f0,
	input  logic [tilt_pkg::FACT_W-1:0]       f1,
	input  logic [tilt_pkg::FACT_W-1:0]       f2,
	input  logic [tilt_pkg::FACT_W-1:0]       f3,
	output logic                              done,
	output logic [tilt_pkg::PROD_W-1:0]       prod
);

	logic                              busy_q;
	logic [1:0]                        pass_q;
	logic [4:0]                        bit_q;
	logic [tilt_pkg::PROD_W-1:0]       mcand_q;
	logic [tilt_pkg::FACT_W-1:0]       mplier_q;
	logic [tilt_pkg::PROD_W-1:0]       acc_q;
	logic [tilt_pkg::FACT_W-1:0]       f2_q;
	logic [tilt_pkg::FACT_W-1:0]       f3_q;
	logic [tilt_pkg::PROD_W-1:0]       prod_q;
	logic                              done_q;
	logic [tilt_pkg::PROD_W-1:0]       acc_nxt;

	// one shift-add step
	assign acc_nxt = acc_q + (mplier_q[0] ? mcand_q : '0);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pass_q <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (bit_q == 5'(tilt_pkg::FACT_W - 1)) &&
				(pass_q == 2'd2);
			if (start) begin
				busy_q <= 1'b1;
				pass_q <= '0;
				bit_q  <= '0;
			end else if (busy_q) begin
				if (bit_q == 5'(tilt_pkg::FACT_W - 1)) begin
					bit_q <= '0;
					if (pass_q == 2'd2) begin
						busy_q <= 1'b0;
					end else begin
						pass_q <= pass_q + 2'd1;
					end
				end else begin
					bit_q <= bit_q + 5'd1;
				end
			end
		end
	end

	// operand shift registers and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= tilt_pkg::PROD_W'(f0);
			mplier_q <= f1;
			f2_q     <= f2;
			f3_q     <= f3;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (bit_q == 5'(tilt_pkg::FACT_W - 1)) begin
				acc_q <= '0;
				if (pass_q == 2'd2) begin
					prod_q <= acc_nxt;
				end else begin
					mcand_q  <= acc_nxt;
					mplier_q <= (pass_q == 2'd0) ? f2_q : f3_q;
				end
			end else begin
				acc_q    <= acc_nxt;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

[hw/rtl/tilt_cordic.sv]
// tilt_cordic: normalizing doubler and vectoring cordic, returns atan2(x, y) in 2^-13 rad
// depends on tilt_pkg
module tilt_cordic #(
	parameter int CORDIC_STEPS = tilt_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [tilt_pkg::XY_W-1:0]          x_abs,
	input  logic signed [tilt_pkg::XY_W-1:0]   y_in,
	output logic                               done,
	output logic [15:0]                        mag_angle
);

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic signed [tilt_pkg::CW_W-1:0] LIM = tilt_pkg::CW_W'(64'd1 << 40);

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} cstate_t;

	cstate_t                             state_q;
	logic signed [tilt_pkg::CW_W-1:0]    x_q;
	logic signed [tilt_pkg::CW_W-1:0]    y_q;
	logic signed [tilt_pkg::Z_W-1:0]     z_q;
	logic [IW-1:0]                       it_q;
	logic                                done_q;
	logic [15:0]                         ang_q;

	logic signed [tilt_pkg::CW_W-1:0]    xs;
	logic signed [tilt_pkg::CW_W-1:0]    ys;
	logic signed [tilt_pkg::Z_W-1:0]     at;
	logic signed [tilt_pkg::Z_W-1:0]     zc;
	logic [tilt_pkg::Z_W-1:0]            zr;

	// shifted operands and table angle of this step
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = tilt_pkg::Z_W'(tilt_pkg::atan_q20(5'(it_q)));

	// clamp, round and saturate the final angle
	assign zc = z_q[tilt_pkg::Z_W-1] ? '0 : z_q;
	assign zr = (tilt_pkg::Z_W'(zc) + tilt_pkg::Z_W'(64)) >> 7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			it_q    <= '0;
		end else begin
			done_q <= (state_q == C_FIN);
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= tilt_pkg::CW_W'(x_abs);
						y_q     <= tilt_pkg::CW_W'(y_in);
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					// double until one part reaches 2^40, then swap into the right half plane
					if (x_q < LIM && y_q < LIM && y_q > -LIM) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						it_q    <= '0;
						state_q <= C_ITER;
						if (y_q < 0) begin
							x_q <= -y_q;
							y_q <= x_q;
							z_q <= tilt_pkg::HALF_PI_Q20;
						end else begin
							x_q <= y_q;
							y_q <= x_q;
							z_q <= '0;
						end
					end
				end
				C_ITER: begin
					// one vectoring step a cycle
					if (y_q >= 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end
					if (it_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= C_FIN;
					end else begin
						it_q <= it_q + IW'(1);
					end
				end
				C_FIN: begin
					ang_q   <= (zr > tilt_pkg::Z_W'(tilt_pkg::ANGLE_MAX)) ?
						16'(tilt_pkg::ANGLE_MAX) : zr[15:0];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign mag_angle = ang_q;

endmodule

[tb/tilt_angle_checker.sv]
// tilt_angle_checker: watches the sample, result and register channels of the tilt unit
// predicts angle and valid flag per accepted sample and compares in order; needs tilt_pkg
`timescale 1ns / 1ps

module tilt_angle_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] rate_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] angle,
	input  logic               valid_res,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 results
);

	typedef struct packed {
		logic signed [15:0] ang;
		logic               ok;
	} tilt_beat_t;

	localparam longint NORM_TOP = 64'sd1 << 40;

	// arctangent of 2^-i in 2^-20 rad
	longint atan_tab [24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

	logic [15:0]        radius_q;
	logic [12:0]        rate_hz_q;
	logic signed [15:0] last_rate_q;
	tilt_beat_t         angles_due [$];

	// vectoring cordic on (|X|, Y), angle in 2^-13 rad before the sign
	function automatic longint cordic_angle(input longint xin, input longint yin);
		longint x, y, z, t, xs, ys;
		int n;
		x = xin;
		y = yin;
		z = 0;
		n = 0;
		while (x < NORM_TOP && y < NORM_TOP && y > -NORM_TOP && n < 64) begin
			x = x * 2;
			y = y * 2;
			n++;
		end
		// turn into the right half plane
		if (y < 0) begin
			t = x;
			x = -y;
			y = t;
			z = tilt_pkg::HALF_PI_Q20;
		end else begin
			t = x;
			x = y;
			y = t;
		end
		for (int i = 0; i < tilt_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_tab[i];
			end
		end
		if (z < 0)
			z = 0;
		z = (z + 64) >>> 7;
		if (z > tilt_pkg::ANGLE_MAX)
			z = tilt_pkg::ANGLE_MAX;
		return z;
	endfunction

	// corrected acceleration vector and its tilt for one sample
	function automatic tilt_beat_t predict_tilt(input logic signed [15:0] ax,
		input logic signed [15:0] ay, input logic signed [15:0] rz);
		tilt_beat_t r;
		longint d, cw, tw, xv, yv, a;
		longint unsigned mr, md, p;
		d  = longint'(rz) - longint'(last_rate_q);
		mr = (rz < 0) ? -longint'(rz) : longint'(rz);
		md = (d < 0) ? -d : d;
		p  = mr * mr * longint'(radius_q) * longint'(tilt_pkg::CENT_COEF);
		cw = longint'((p + (64'd1 << 39)) >> 40);
		p  = md * longint'(rate_hz_q) * longint'(radius_q) * longint'(tilt_pkg::TAN_COEF);
		tw = longint'((p + (64'd1 << 25)) >> 26);
		if (d < 0)
			tw = -tw;
		xv = longint'(ax) * 256 + tw;
		yv = longint'(ay) * 256 + cw;
		r.ok = (xv != 0) || (yv != 0);
		a = 0;
		if (r.ok) begin
			a = cordic_angle((xv < 0) ? -xv : xv, yv);
			if (xv > 0)
				a = -a;
		end
		r.ang = a[15:0];
		return r;
	endfunction

	// track registers, predict on sample beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		tilt_beat_t want;
		if (!arst_n) begin
			radius_q    <= tilt_pkg::RADIUS_RST;
			rate_hz_q   <= tilt_pkg::RATE_RST;
			last_rate_q <= '0;
			errors      <= 0;
			results     <= 0;
			angles_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tilt_pkg::REG_RADIUS)
					radius_q <= cfg_data;
				else if (cfg_index == tilt_pkg::REG_RATE)
					rate_hz_q <= cfg_data[12:0];
			end
			if (in_valid && !in_stall) begin
				angles_due.push_back(predict_tilt(accel_x, accel_y, rate_z));
				last_rate_q <= rate_z;
			end
			if (out_valid && !out_stall) begin
				results <= results + 1;
				if (angles_due.size() == 0) begin
					$display("%0t: result beat with nothing due: angle %0d valid %0b",
						$time, angle, valid_res);
					errors <= errors + 1;
				end else begin
					want = angles_due.pop_front();
					if (want.ang !== angle || want.ok !== valid_res) begin
						$display("%0t: angle exp %0d got %0d, valid_res exp %0b got %0b",
							$time, want.ang, angle, want.ok, valid_res);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	assign pending = angles_due.size();

endmodule

[tb/tilt_angle_from_imu_unit_test.sv]
// tilt_angle_from_imu_unit_test: stimulus, stalls and verdict for the tilt angle unit
// depends on tilt_pkg, tilt_angle_from_imu_unit and tilt_angle_checker
`timescale 1ns / 1ps

module tilt_angle_from_imu_unit_test;

	// an index that names no register
	localparam logic [7:0] REG_NONE = 8'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] rate_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] angle;
	logic               valid_res;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	int                 errors, pending, results;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	bit long_hold = 1'b0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;
	int samples_sent = 0;
	int cfg_writes = 0;
	logic signed [15:0] last_rz = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tilt_angle_from_imu_unit dut (.*);

	tilt_angle_checker chk (.*);

	// result side stalls: long hold-off once requested, otherwise random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (long_hold && !hold_done) begin
			out_stall   <= 1'b1;
			hold_cycles <= 399;
			hold_done   <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
		input logic signed [15:0] rz);
		bit took;
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x  <= ax;
		accel_y  <= ay;
		rate_z   <= rz;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		last_rz = rz;
		samples_sent++;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	// let every due result drain, plus the unit's own latency
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// mostly plausible motion: gravity-sized accel, rate drifting from the last one
	task automatic random_samples(input int count);
		logic signed [15:0] ax, ay, rz;
		int kind;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(9);
			if (kind < 6) begin
				ax = 16'($signed($urandom_range(32767)) - 16384);
				ay = 16'($signed($urandom_range(32767)) - 16384);
				rz = 16'(last_rz + $signed($urandom_range(2047)) - 1024);
			end else if (kind < 8) begin
				ax = 16'($urandom);
				ay = 16'($urandom);
				rz = 16'($urandom);
			end else begin
				ax = 16'($signed($urandom_range(15)) - 8);
				ay = 16'($signed($urandom_range(15)) - 8);
				rz = $urandom_range(1) ? last_rz : 16'sd0;
			end
			send_sample(ax, ay, rz);
			if (k == count / 2 && $urandom_range(1))
				drain();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, zero vector, extremes, straight down
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd16384, 16'sd0);
		send_sample(16'sd0, -16'sd16384, 16'sd0);
		send_sample(16'sd16384, 16'sd0, 16'sd0);
		send_sample(-16'sd16384, 16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
		send_sample(16'sd1, -16'sd1, 16'sd32767);
		send_sample(-16'sd1, 16'sd1, -16'sd32768);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		drain();

		// extreme registers, zero sample rate, out of range index, oversized rate value
		write_reg(tilt_pkg::REG_RADIUS, 16'hFFFF);
		write_reg(tilt_pkg::REG_RATE, 16'hFFFF);
		write_reg(REG_NONE, 16'h1234);
		send_sample(16'sd0, 16'sd0, 16'sd32767);
		send_sample(16'sd0, 16'sd0, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767, 16'sd32767);
		drain();
		write_reg(tilt_pkg::REG_RATE, 16'd0);
		send_sample(16'sd0, -16'sd100, 16'sd4000);
		send_sample(16'sd0, 16'sd0, -16'sd4000);
		drain();
		write_reg(tilt_pkg::REG_RADIUS, 16'd0);
		write_reg(tilt_pkg::REG_RATE, 16'd1);
		send_sample(16'sd0, 16'sd0, 16'sd32767);
		send_sample(16'sd0, -16'sd5, -16'sd32768);
		drain();

		// sender gaps 26, receiver stalls 46
		write_reg(tilt_pkg::REG_RADIUS, tilt_pkg::RADIUS_RST);
		write_reg(tilt_pkg::REG_RATE, 16'(tilt_pkg::RATE_RST));
		send_gap_pct   = 26;
		recv_stall_pct = 46;
		random_samples(600);
		drain();

		// swapped, with larger radius and rate
		write_reg(tilt_pkg::REG_RADIUS, 16'd40000);
		write_reg(tilt_pkg::REG_RATE, 16'd8000);
		send_gap_pct   = 46;
		recv_stall_pct = 26;
		random_samples(600);
		drain();

		// no idling; receiver holds off long so the unit backs up into its input
		write_reg(tilt_pkg::REG_RADIUS, 16'd655);
		write_reg(tilt_pkg::REG_RATE, 16'd1000);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		long_hold      = 1'b1;
		random_samples(600);
		drain();

		$display("covered %0d samples and %0d register writes across three stall mixes",
			samples_sent, cfg_writes);
		$display("%0d results compared, including long output hold-off and drained pauses",
			results);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/tilt_pkg.sv
hw/rtl/tilt_smul.sv
hw/rtl/tilt_cordic.sv
hw/rtl/tilt_angle_from_imu_unit.sv
tb/tilt_angle_checker.sv
tb/tilt_angle_from_imu_unit_test.sv
